// ===== design/wsms_pkg.sv =====
// Shared types and constants of the weighted score minimum selector.
package wsms_pkg;

	localparam int WEIGHT_W    = 16;
	localparam int WEIGHT_FRAC = 8;
	localparam int BURST_W     = 24;
	localparam int WAIT_W      = 16;
	localparam int TIME_W      = 20;
	localparam int PRIO_W      = 8;
	localparam int ORDER_W     = 16;
	localparam int IDENT_W     = 8;
	localparam int INDEX_W     = 6;
	localparam int CFG_IDX_W   = 2;

	localparam int IN_Q_DEPTH  = 4;
	localparam int RES_Q_DEPTH = 2;

	localparam logic [WEIGHT_W-1:0] AGING_RESET    = 16'd256;
	localparam logic [WEIGHT_W-1:0] IO_RESET       = 16'd768;
	localparam logic [WEIGHT_W-1:0] PRIORITY_RESET = 16'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AGING    = 2'd0,
		REG_IO       = 2'd1,
		REG_PRIORITY = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] aging;
		logic [WEIGHT_W-1:0] io;
		logic [WEIGHT_W-1:0] prio;
	} weights_t;

	typedef struct packed {
		logic               ready;
		logic [BURST_W-1:0] burst;
		logic [WAIT_W-1:0]  wait_ticks;
		logic [TIME_W-1:0]  cpu;
		logic [TIME_W-1:0]  io;
		logic [PRIO_W-1:0]  prio;
		logic [ORDER_W-1:0] order;
		logic [IDENT_W-1:0] ident;
		logic               last;
	} raw_item_t;

	typedef struct packed {
		logic               score_en;
		logic               last;
		logic [INDEX_W-1:0] index;
		logic [BURST_W-1:0] burst;
		logic [WAIT_W-1:0]  wait_ticks;
		logic [TIME_W-1:0]  cpu;
		logic [TIME_W-1:0]  io;
		logic [PRIO_W-1:0]  prio;
		logic [ORDER_W-1:0] order;
		logic [IDENT_W-1:0] ident;
	} work_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               found;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_ACC,
		B_EMIT
	} back_state_t;

endpackage

// ===== design/weighted_score_min_selector_top.sv =====
// Top level of the weighted score minimum selector: front, work queue, back end, result queue.
// Back end: each scored entry passes the divider, which forms two bits of the I/O share
// per cycle, and then an accumulate step; after the last entry the scan result goes to the
// result queue from the emit state, which waits while that queue is full.
// The back end takes a new entry only once the last is done; unready entries skip the divider.
// Reset: arst_n clears all control state and loads the default weights; no clearing pass.
module weighted_score_min_selector_top
	import wsms_pkg::*;
#(
	parameter int MAX_ENTRIES = 64,
	parameter int FRAC_BITS   = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// Entry request channel
	input  logic                 push,
	output logic                 full,
	input  logic                 entry_ready,
	input  logic [BURST_W-1:0]   burst_est,
	input  logic [WAIT_W-1:0]    wait_count,
	input  logic [TIME_W-1:0]    cpu_time,
	input  logic [TIME_W-1:0]    io_time,
	input  logic [PRIO_W-1:0]    priority_req,
	input  logic [ORDER_W-1:0]   queue_rank,
	input  logic [IDENT_W-1:0]   process_id,
	input  logic                 last_entry,

	// Result request channel
	output logic                 empty,
	input  logic                 pop,
	output logic [INDEX_W-1:0]   chosen_index,
	output logic                 found,

	// Configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WEIGHT_W-1:0]  cfg_data
);

	localparam int WORK_W = $bits(work_item_t);
	localparam int RES_W  = $bits(result_t);

	weights_t         weights_q;
	raw_item_t        raw_item;
	work_item_t       in_q_wr_item;
	work_item_t       in_q_rd_item;
	logic [WORK_W-1:0] in_q_rd_data;
	logic             in_q_push;
	logic             in_q_full;
	logic             in_q_pop;
	logic             in_q_empty;
	result_t          res_wr_item;
	result_t          res_rd_item;
	logic [RES_W-1:0] res_rd_data;
	logic             res_push;
	logic             res_full;

	// Users change weights only while the block is idle; unenforced, every write is taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q.aging <= AGING_RESET;
			weights_q.io    <= IO_RESET;
			weights_q.prio  <= PRIORITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_AGING:    weights_q.aging <= cfg_data;
				REG_IO:       weights_q.io    <= cfg_data;
				REG_PRIORITY: weights_q.prio  <= cfg_data;
				default:      weights_q       <= weights_q;
			endcase
		end
	end

	// Gather the entry fields into one request.
	always_comb begin
		raw_item.ready      = entry_ready;
		raw_item.burst      = burst_est;
		raw_item.wait_ticks = wait_count;
		raw_item.cpu        = cpu_time;
		raw_item.io         = io_time;
		raw_item.prio       = priority_req;
		raw_item.order      = queue_rank;
		raw_item.ident      = process_id;
		raw_item.last       = last_entry;
	end

	// Stall the entry channel only when the work queue is full.
	assign full = in_q_full;

	wsms_front #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.raw_item(raw_item),
		.q_full  (in_q_full),
		.q_push  (in_q_push),
		.q_item  (in_q_wr_item)
	);

	// Work queue decouples entry acceptance from scoring.
	wsms_fifo #(
		.WIDTH(WORK_W),
		.DEPTH(IN_Q_DEPTH)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (in_q_push),
		.wr_data(in_q_wr_item),
		.full   (in_q_full),
		.rd_en  (in_q_pop),
		.rd_data(in_q_rd_data),
		.empty  (in_q_empty)
	);

	assign in_q_rd_item = in_q_rd_data;

	wsms_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.weights (weights_q),
		.q_empty (in_q_empty),
		.q_item  (in_q_rd_item),
		.q_pop   (in_q_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res_item(res_wr_item)
	);

	// Result queue lets the back end start the next scan while a result waits.
	wsms_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_Q_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_wr_item),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_rd_data),
		.empty  (empty)
	);

	assign res_rd_item  = res_rd_data;
	assign chosen_index = res_rd_item.index;
	assign found        = res_rd_item.found;

`ifndef SYNTHESIS
	a_work_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		in_q_push |-> !in_q_full)
		else $error("front wrote into a full work queue");

	a_res_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("back end pushed a result into a full result queue");

	a_pop_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_q_pop |-> !in_q_empty)
		else $error("back end popped an empty work queue");

	a_not_found_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !found) |-> (chosen_index == '0))
		else $error("result without a winner carries a nonzero index");
`endif

endmodule

// ===== design/wsms_fifo.sv =====
// Small synchronous queue used between the front, the back and the result port.
module wsms_fifo
	import wsms_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_ok;
	logic             rd_ok;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_ok   = wr_en && !full;
	assign rd_ok   = rd_en && !empty;
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_ok, rd_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/wsms_front.sv =====
// Front end: accept entries, track table position, drop entries that need no work.
module wsms_front
	import wsms_pkg::*;
#(
	parameter int MAX_ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  raw_item_t  raw_item,
	input  logic       q_full,
	output logic       q_push,
	output work_item_t q_item
);

	localparam int POS_W = $clog2(MAX_ENTRIES + 1);

	logic [POS_W-1:0] pos_q;
	logic             accept;
	logic             in_range;
	logic             score_en;

	assign accept   = push && !q_full;
	assign in_range = (pos_q < POS_W'(MAX_ENTRIES));
	assign score_en = raw_item.ready && in_range;
	// Forward only entries that get scored or that close the scan.
	assign q_push   = accept && (score_en || raw_item.last);

	always_comb begin
		q_item            = '0;
		q_item.score_en   = score_en;
		q_item.last       = raw_item.last;
		q_item.index      = INDEX_W'(pos_q);
		q_item.burst      = raw_item.burst;
		q_item.wait_ticks = raw_item.wait_ticks;
		q_item.cpu        = raw_item.cpu;
		q_item.io         = raw_item.io;
		q_item.prio       = raw_item.prio;
		q_item.order      = raw_item.order;
		q_item.ident      = raw_item.ident;
	end

	// Advance the position, saturate at the table depth, restart on the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			priority if (raw_item.last) begin
				pos_q <= '0;
			end else if (in_range) begin
				pos_q <= pos_q + 1'b1;
			end else begin
				pos_q <= pos_q;
			end
		end
	end

endmodule

// ===== design/wsms_div.sv =====
// Radix-4 restoring divider for the I/O share io / (cpu + io).
module wsms_div
	import wsms_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [TIME_W-1:0]    io,
	input  logic [TIME_W-1:0]    cpu,
	output div_stat_t            stat,
	output logic [FRAC_BITS:0]   share
);

	localparam int ITERS = (FRAC_BITS + 1) / 2;
	localparam int STEPS = 2 * ITERS;
	localparam int CNT_W = $clog2(ITERS + 1);
	localparam int SUM_W = TIME_W + 1;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] rem_q;
	logic [STEPS-1:0] quo_q;
	logic             zero_q;
	logic             whole_q;
	logic [SUM_W-1:0] rem_d;
	logic [STEPS-1:0] quo_d;
	logic [SUM_W:0]   trial;

	// Two quotient bits per cycle; remainder stays below the divisor when cpu time is nonzero.
	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		trial = '0;
		for (int k = 0; k < 2; k++) begin
			trial = {rem_d, 1'b0};
			if (trial >= {1'b0, sum_q}) begin
				trial = trial - {1'b0, sum_q};
				quo_d = {quo_d[STEPS-2:0], 1'b1};
			end else begin
				quo_d = {quo_d[STEPS-2:0], 1'b0};
			end
			rem_d = trial[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ITERS);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_q   <= SUM_W'(cpu) + SUM_W'(io);
			rem_q   <= SUM_W'(io);
			quo_q   <= '0;
			zero_q  <= (io == '0);
			whole_q <= (cpu == '0);
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);

	// No I/O gives zero share, no CPU time gives a share of exactly one.
	always_comb begin
		priority if (zero_q) begin
			share = '0;
		end else if (whole_q) begin
			share = {1'b1, {FRAC_BITS{1'b0}}};
		end else begin
			share = {1'b0, quo_q[STEPS-1:STEPS-FRAC_BITS]};
		end
	end

endmodule

// ===== design/wsms_back.sv =====
// Back end: score one entry at a time, keep the running minimum, emit the scan result.
module wsms_back
	import wsms_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  weights_t   weights,
	input  logic       q_empty,
	input  work_item_t q_item,
	output logic       q_pop,
	input  logic       res_full,
	output logic       res_push,
	output result_t    res_item
);

	localparam int SHARE_W  = FRAC_BITS + 1;
	localparam int AGE_PW   = WAIT_W + WEIGHT_W;
	localparam int PRIO_PW  = PRIO_W + WEIGHT_W;
	localparam int IO_PW    = SHARE_W + WEIGHT_W;
	localparam int AGE_TW   = AGE_PW + FRAC_BITS - WEIGHT_FRAC;
	localparam int PRIO_TW  = PRIO_PW + FRAC_BITS - WEIGHT_FRAC;
	localparam int IO_TW    = IO_PW - WEIGHT_FRAC;
	localparam int SCORE_W  = BURST_W + FRAC_BITS + 2;

	back_state_t state_q;
	back_state_t state_d;

	work_item_t                 item_q;
	logic [AGE_PW-1:0]          age_prod_s1;
	logic [PRIO_PW-1:0]         prio_prod_s1;
	logic signed [SCORE_W-1:0]  part_s2;
	logic [IO_PW-1:0]           io_prod_s2;

	logic                       have_best_q;
	logic [INDEX_W-1:0]         best_index_q;
	logic signed [SCORE_W-1:0]  best_score_q;
	logic [ORDER_W-1:0]         best_order_q;
	logic [IDENT_W-1:0]         best_ident_q;

	logic                       div_start;
	div_stat_t                  div_stat;
	logic [SHARE_W-1:0]         div_share;

	logic [AGE_PW+FRAC_BITS-1:0]  age_wide;
	logic [PRIO_PW+FRAC_BITS-1:0] prio_wide;
	logic [AGE_TW-1:0]            age_term;
	logic [PRIO_TW-1:0]           prio_term;
	logic [IO_TW-1:0]             io_term;
	logic signed [SCORE_W-1:0]    burst_s;
	logic signed [SCORE_W-1:0]    age_s;
	logic signed [SCORE_W-1:0]    prio_s;
	logic signed [SCORE_W-1:0]    io_s;
	logic signed [SCORE_W-1:0]    score;
	logic                         take;
	logic                         in_div;
	logic                         in_acc;

	wsms_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.io    (q_item.io),
		.cpu   (q_item.cpu),
		.stat  (div_stat),
		.share (div_share)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					state_d = q_item.score_en ? B_DIV : B_EMIT;
				end
			end
			B_DIV: begin
				if (div_stat.done) begin
					state_d = B_ACC;
				end
			end
			B_ACC: begin
				state_d = item_q.last ? B_EMIT : B_IDLE;
			end
			B_EMIT: begin
				if (!res_full) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == B_IDLE) && !q_empty;
		div_start = q_pop && q_item.score_en;
		in_div    = (state_q == B_DIV);
		in_acc    = (state_q == B_ACC);
		res_push  = (state_q == B_EMIT) && !res_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Bring the terms weighted by the Q8.8 weights to the score's fraction width, floor.
	assign age_wide  = {age_prod_s1, {FRAC_BITS{1'b0}}};
	assign prio_wide = {prio_prod_s1, {FRAC_BITS{1'b0}}};
	assign age_term  = age_wide[AGE_PW+FRAC_BITS-1:WEIGHT_FRAC];
	assign prio_term = prio_wide[PRIO_PW+FRAC_BITS-1:WEIGHT_FRAC];
	assign io_term   = io_prod_s2[IO_PW-1:WEIGHT_FRAC];
	assign burst_s   = SCORE_W'(item_q.burst);
	assign age_s     = SCORE_W'(age_term);
	assign prio_s    = SCORE_W'(prio_term);
	assign io_s      = SCORE_W'(io_term);
	assign score     = part_s2 - io_s;

	assign take = !have_best_q || (score < best_score_q) ||
		((score == best_score_q) && ((item_q.order < best_order_q) ||
		((item_q.order == best_order_q) && (item_q.ident < best_ident_q))));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q       <= q_item;
			age_prod_s1  <= q_item.wait_ticks * weights.aging;
			prio_prod_s1 <= q_item.prio * weights.prio;
		end
		if (in_div) begin
			part_s2 <= burst_s - age_s + prio_s;
			if (div_stat.done) begin
				io_prod_s2 <= div_share * weights.io;
			end
		end
	end

	// Hold the running minimum; drop it once the scan result is out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q  <= 1'b0;
			best_index_q <= '0;
			best_score_q <= '0;
			best_order_q <= '0;
			best_ident_q <= '0;
		end else if (res_push) begin
			have_best_q  <= 1'b0;
			best_index_q <= '0;
			best_score_q <= '0;
			best_order_q <= '0;
			best_ident_q <= '0;
		end else if (in_acc && take) begin
			have_best_q  <= 1'b1;
			best_index_q <= item_q.index;
			best_score_q <= score;
			best_order_q <= item_q.order;
			best_ident_q <= item_q.ident;
		end
	end

	assign res_item.index = have_best_q ? best_index_q : '0;
	assign res_item.found = have_best_q;

endmodule
